>>> rtl/sctp_pkg.sv
// ----------------------------------------------------------------------------
// sctp_pkg: shared constants and types of the sector cache tag controller
// Geometry of the tag store, field widths and operation codes.
// ----------------------------------------------------------------------------
package sctp_pkg;

    // tag store geometry
    localparam int ENTRIES      = 8;
    localparam int IDX_W        = $clog2(ENTRIES);
    localparam int COUNTER_BITS = 14;
    localparam int SECTOR_SHIFT = 9;
    localparam int ADDR_W       = 32;
    localparam int SECTOR_W     = ADDR_W - SECTOR_SHIFT;
    localparam int OP_W         = 2;

    localparam logic [IDX_W-1:0]        LAST_IDX    = IDX_W'(ENTRIES - 1);
    localparam logic [COUNTER_BITS-1:0] COUNTER_MAX = {COUNTER_BITS{1'b1}};

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_FLUSH  = 4'b1000
    } t_state;

endpackage

>>> rtl/sector_cache_tag_policy.sv
// ----------------------------------------------------------------------------
// sector_cache_tag_policy: tag and replacement controller of a sector cache
// Fully associative write-back tag store with least-written replacement.
// ----------------------------------------------------------------------------
// Usage
//   A transaction is taken at a rising edge with start high and busy low.
//   i_operation selects read, write or flush; i_byte_address gives the byte
//   address, whose sector is the address shifted right by SECTOR_SHIFT.
//   Operation code three is taken and ignored: no result, no busy time.
//   Results appear for one cycle with o_result_strobe high; o_last marks the
//   final result of a transaction. The receiver cannot stall the block.
// Timing
//   Read or write: one cycle per entry while a single comparator pair walks
//   the tag store, then a decision state; the result strobe is registered
//   from the decision state, and busy is high meanwhile.
//   Flush: one cycle per entry, a write-back result in the cycle after each
//   dirty entry is visited; the final result is the last write-back, or with
//   no dirty entry a bare result on the cycle busy falls.
// Reset
//   i_rst_n low clears valid, dirty and write counters at once; sector tags
//   are only read for valid entries and carry no reset.
// ----------------------------------------------------------------------------
module sector_cache_tag_policy (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sctp_pkg::OP_W-1:0]     i_operation,
    input  logic [sctp_pkg::ADDR_W-1:0]   i_byte_address,
    output logic                          o_result_strobe,
    output logic                          o_hit,
    output logic [sctp_pkg::IDX_W-1:0]    o_entry_index,
    output logic                          o_writeback_valid,
    output logic [sctp_pkg::SECTOR_W-1:0] o_writeback_sector,
    output logic                          o_fill_valid,
    output logic [sctp_pkg::SECTOR_W-1:0] o_fill_sector,
    output logic                          o_last
);

    // state
    sctp_pkg::t_state r_state, n_state;

    logic [sctp_pkg::ENTRIES-1:0]      r_valid;
    logic [sctp_pkg::ENTRIES-1:0]      r_dirty;
    logic [sctp_pkg::COUNTER_BITS-1:0] r_counter [sctp_pkg::ENTRIES];
    logic [sctp_pkg::SECTOR_W-1:0]     r_sector  [sctp_pkg::ENTRIES];

    // per-transaction working registers
    logic [sctp_pkg::IDX_W-1:0]        r_idx;
    logic                              r_is_write;
    logic [sctp_pkg::SECTOR_W-1:0]     r_req_sector;
    logic                              r_hit_found;
    logic [sctp_pkg::IDX_W-1:0]        r_hit_idx;
    logic [sctp_pkg::COUNTER_BITS-1:0] r_hit_cnt;
    logic                              r_inv_found;
    logic [sctp_pkg::IDX_W-1:0]        r_inv_idx;
    logic [sctp_pkg::COUNTER_BITS-1:0] r_min_cnt;
    logic [sctp_pkg::IDX_W-1:0]        r_min_idx;
    logic [sctp_pkg::SECTOR_W-1:0]     r_min_sector;
    logic                              r_min_dirty;
    logic                              r_flush_emitted;

    // output registers
    logic                              r_strobe;
    logic                              r_hit;
    logic [sctp_pkg::IDX_W-1:0]        r_entry_index;
    logic                              r_wb_valid;
    logic [sctp_pkg::SECTOR_W-1:0]     r_wb_sector;
    logic                              r_fill_valid;
    logic [sctp_pkg::SECTOR_W-1:0]     r_fill_sector;
    logic                              r_last;

    logic accept;
    assign busy   = (r_state != sctp_pkg::ST_IDLE);
    assign accept = start && !busy;

    // shared scan unit: one entry read, one tag compare, one counter compare
    logic [sctp_pkg::SECTOR_W-1:0]     scan_sector;
    logic [sctp_pkg::COUNTER_BITS-1:0] scan_cnt;
    logic                              scan_valid;
    logic                              scan_match;
    logic                              scan_less;
    logic                              scan_at_end;

    assign scan_sector = r_sector[r_idx];
    assign scan_cnt    = r_counter[r_idx];
    assign scan_valid  = r_valid[r_idx];
    assign scan_match  = scan_valid && (scan_sector == r_req_sector);
    assign scan_less   = (scan_cnt < r_min_cnt);
    assign scan_at_end = (r_idx == sctp_pkg::LAST_IDX);

    // decision for an access
    logic                              dec_hit;
    logic [sctp_pkg::IDX_W-1:0]        dec_idx;
    logic                              dec_wb;
    logic [sctp_pkg::COUNTER_BITS-1:0] dec_base_cnt;
    logic [sctp_pkg::COUNTER_BITS-1:0] dec_new_cnt;

    always_comb begin
        dec_hit = r_hit_found;
        dec_wb  = 1'b0;
        if (r_hit_found) begin
            dec_idx = r_hit_idx;
        end else if (r_inv_found) begin
            dec_idx = r_inv_idx;
        end else begin
            dec_idx = r_min_idx;
            dec_wb  = r_min_dirty;
        end
        dec_base_cnt = r_hit_found ? r_hit_cnt : '0;
        if (r_is_write && (dec_base_cnt != sctp_pkg::COUNTER_MAX)) begin
            dec_new_cnt = dec_base_cnt + 1'b1;
        end else begin
            dec_new_cnt = dec_base_cnt;
        end
    end

    // flush step: is the current entry dirty, and does any other remain
    logic [sctp_pkg::ENTRIES-1:0] idx_onehot;
    logic [sctp_pkg::ENTRIES-1:0] pending;
    logic                         fl_cur;
    logic                         fl_others;

    assign idx_onehot = {{(sctp_pkg::ENTRIES-1){1'b0}}, 1'b1} << r_idx;
    assign pending    = r_valid & r_dirty;
    assign fl_cur     = pending[r_idx];
    assign fl_others  = |(pending & ~idx_onehot);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sctp_pkg::ST_IDLE: begin
                if (accept) begin
                    if ((i_operation == sctp_pkg::OP_READ) ||
                        (i_operation == sctp_pkg::OP_WRITE)) begin
                        n_state = sctp_pkg::ST_SCAN;
                    end else if (i_operation == sctp_pkg::OP_FLUSH) begin
                        n_state = sctp_pkg::ST_FLUSH;
                    end
                end
            end
            sctp_pkg::ST_SCAN: begin
                if (scan_at_end) n_state = sctp_pkg::ST_DECIDE;
            end
            sctp_pkg::ST_DECIDE: begin
                n_state = sctp_pkg::ST_IDLE;
            end
            sctp_pkg::ST_FLUSH: begin
                if (scan_at_end) n_state = sctp_pkg::ST_IDLE;
            end
            default: n_state = sctp_pkg::ST_IDLE;
        endcase
    end

    // control state, tag flags and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= sctp_pkg::ST_IDLE;
            r_valid         <= '0;
            r_dirty         <= '0;
            r_strobe        <= 1'b0;
            r_idx           <= '0;
            r_hit_found     <= 1'b0;
            r_inv_found     <= 1'b0;
            r_flush_emitted <= 1'b0;
            for (int i = 0; i < sctp_pkg::ENTRIES; i++) begin
                r_counter[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            unique case (r_state)
                sctp_pkg::ST_IDLE: begin
                    r_idx           <= '0;
                    r_hit_found     <= 1'b0;
                    r_inv_found     <= 1'b0;
                    r_flush_emitted <= 1'b0;
                end
                sctp_pkg::ST_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (scan_match && !r_hit_found) r_hit_found <= 1'b1;
                    if (!scan_valid && !r_inv_found) r_inv_found <= 1'b1;
                end
                sctp_pkg::ST_DECIDE: begin
                    r_strobe          <= 1'b1;
                    r_valid[dec_idx]  <= 1'b1;
                    r_dirty[dec_idx]  <= r_is_write ? 1'b1 :
                                         (dec_hit ? r_dirty[dec_idx] : 1'b0);
                    r_counter[dec_idx] <= dec_new_cnt;
                end
                sctp_pkg::ST_FLUSH: begin
                    r_idx            <= r_idx + 1'b1;
                    r_dirty[r_idx]   <= 1'b0;
                    r_counter[r_idx] <= '0;
                    if (fl_cur) r_flush_emitted <= 1'b1;
                    r_strobe <= fl_cur || (scan_at_end && !r_flush_emitted);
                end
                default: ;
            endcase
        end
    end

    // payload: request capture, scan records, sector tags, result fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_write   <= (i_operation == sctp_pkg::OP_WRITE);
            r_req_sector <= i_byte_address[sctp_pkg::ADDR_W-1:sctp_pkg::SECTOR_SHIFT];
        end
        case (r_state)
            sctp_pkg::ST_SCAN: begin
                if (scan_match && !r_hit_found) begin
                    r_hit_idx <= r_idx;
                    r_hit_cnt <= scan_cnt;
                end
                if (!scan_valid && !r_inv_found) r_inv_idx <= r_idx;
                // first entry seeds the minimum, strict less keeps lowest index
                if ((r_idx == '0) || scan_less) begin
                    r_min_cnt    <= scan_cnt;
                    r_min_idx    <= r_idx;
                    r_min_sector <= scan_sector;
                    r_min_dirty  <= r_dirty[r_idx];
                end
            end
            sctp_pkg::ST_DECIDE: begin
                if (!dec_hit) r_sector[dec_idx] <= r_req_sector;
                r_hit         <= dec_hit;
                r_entry_index <= dec_idx;
                r_wb_valid    <= dec_wb;
                r_wb_sector   <= dec_wb ? r_min_sector : '0;
                r_fill_valid  <= !dec_hit;
                r_fill_sector <= dec_hit ? '0 : r_req_sector;
                r_last        <= 1'b1;
            end
            sctp_pkg::ST_FLUSH: begin
                r_hit         <= 1'b0;
                r_entry_index <= fl_cur ? r_idx : '0;
                r_wb_valid    <= fl_cur;
                r_wb_sector   <= fl_cur ? scan_sector : '0;
                r_fill_valid  <= 1'b0;
                r_fill_sector <= '0;
                r_last        <= fl_cur ? !fl_others : 1'b1;
            end
            default: ;
        endcase
    end

    assign o_result_strobe    = r_strobe;
    assign o_hit              = r_hit;
    assign o_entry_index      = r_entry_index;
    assign o_writeback_valid  = r_wb_valid;
    assign o_writeback_sector = r_wb_sector;
    assign o_fill_valid       = r_fill_valid;
    assign o_fill_sector      = r_fill_sector;
    assign o_last             = r_last;

    // a hit never requests a fill or a write-back
    a_hit_no_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && o_hit) |-> (!o_fill_valid && !o_writeback_valid))
        else $error("hit result carries a transfer request");

    // a result that is not last is always followed by more work
    a_more_results: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_strobe && !o_last) |-> busy)
        else $error("non-final result with the controller idle");

    // an accepted access is followed by busy, with no result strobe yet
    a_access_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ((i_operation == sctp_pkg::OP_READ) ||
                    (i_operation == sctp_pkg::OP_WRITE))) |=> (busy && !o_result_strobe))
        else $error("access transaction not held busy");

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the sector cache tag controller
// Drives read, write, flush and ignored transactions through the start/busy
// handshake and keeps its own copy of the tag store: valid and dirty bits,
// write counters and sector tags. Every result strobe is compared field by
// field with the oldest predicted result. Directed tests cover the empty
// flush, hits, misses, eviction with and without write-back, a flush of a
// fully dirty cache and victim choice by write count. A random mix with
// bursts of sender idling follows.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RANDOM_ITEMS   = 240;
    localparam int QUIET_TAIL     = 45;
    localparam int HOT_WRITES     = 24;
    localparam int DRAIN_CYCLES   = 24;
    localparam int WATCHDOG_LIMIT = 1000;

    // one predicted result of the controller
    typedef struct packed {
        logic                          hit;
        logic [sctp_pkg::IDX_W-1:0]    entry;
        logic                          wb_valid;
        logic [sctp_pkg::SECTOR_W-1:0] wb_sector;
        logic                          fill_valid;
        logic [sctp_pkg::SECTOR_W-1:0] fill_sector;
        logic                          last;
    } t_tag_result;

    logic                          i_clk          = 1'b0;
    logic                          i_rst_n        = 1'b0;
    logic                          start          = 1'b0;
    logic [sctp_pkg::OP_W-1:0]     i_operation    = sctp_pkg::OP_NONE;
    logic [sctp_pkg::ADDR_W-1:0]   i_byte_address = '0;
    logic                          busy;
    logic                          o_result_strobe;
    logic                          o_hit;
    logic [sctp_pkg::IDX_W-1:0]    o_entry_index;
    logic                          o_writeback_valid;
    logic [sctp_pkg::SECTOR_W-1:0] o_writeback_sector;
    logic                          o_fill_valid;
    logic [sctp_pkg::SECTOR_W-1:0] o_fill_sector;
    logic                          o_last;

    // tag store as the testbench sees it
    logic                              line_valid  [sctp_pkg::ENTRIES];
    logic                              line_dirty  [sctp_pkg::ENTRIES];
    logic [sctp_pkg::COUNTER_BITS-1:0] line_writes [sctp_pkg::ENTRIES];
    logic [sctp_pkg::SECTOR_W-1:0]     line_sector [sctp_pkg::ENTRIES];

    t_tag_result expected_results[$];

    int mismatch_count  = 0;
    int checked_count   = 0;
    int accepted_count  = 0;
    int hit_count       = 0;
    int evict_wb_count  = 0;
    int flush_count     = 0;
    int quiet_cycles    = 0;

    sector_cache_tag_policy i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_byte_address     (i_byte_address),
        .o_result_strobe    (o_result_strobe),
        .o_hit              (o_hit),
        .o_entry_index      (o_entry_index),
        .o_writeback_valid  (o_writeback_valid),
        .o_writeback_sector (o_writeback_sector),
        .o_fill_valid       (o_fill_valid),
        .o_fill_sector      (o_fill_sector),
        .o_last             (o_last)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // lookup, replacement and counter update for a read or write
    function automatic void predict_access(input logic is_write,
                                           input logic [sctp_pkg::ADDR_W-1:0] addr);
        logic [sctp_pkg::SECTOR_W-1:0]     sector;
        logic [sctp_pkg::COUNTER_BITS-1:0] lowest;
        t_tag_result                       res;
        int                                slot;
        sector = addr[sctp_pkg::ADDR_W-1:sctp_pkg::SECTOR_SHIFT];
        res    = '0;
        slot   = -1;
        for (int i = 0; i < sctp_pkg::ENTRIES; i++)
            if (slot < 0 && line_valid[i] && line_sector[i] == sector)
                slot = i;
        if (slot >= 0) begin
            res.hit = 1'b1;
            hit_count++;
        end else begin
            // first free entry, else the least written one
            for (int i = 0; i < sctp_pkg::ENTRIES; i++)
                if (slot < 0 && !line_valid[i])
                    slot = i;
            if (slot < 0) begin
                slot   = 0;
                lowest = line_writes[0];
                for (int i = 1; i < sctp_pkg::ENTRIES; i++)
                    if (line_writes[i] < lowest) begin
                        lowest = line_writes[i];
                        slot   = i;
                    end
                if (line_dirty[slot]) begin
                    res.wb_valid  = 1'b1;
                    res.wb_sector = line_sector[slot];
                    evict_wb_count++;
                end
            end
            line_valid[slot]  = 1'b1;
            line_dirty[slot]  = 1'b0;
            line_writes[slot] = '0;
            line_sector[slot] = sector;
            res.fill_valid    = 1'b1;
            res.fill_sector   = sector;
        end
        if (is_write) begin
            line_dirty[slot] = 1'b1;
            if (line_writes[slot] != sctp_pkg::COUNTER_MAX)
                line_writes[slot] = line_writes[slot] + 1'b1;
        end
        res.entry = sctp_pkg::IDX_W'(slot);
        res.last  = 1'b1;
        expected_results.push_back(res);
    endfunction

    // one write-back per valid dirty entry, then dirty bits and counters cleared
    function automatic void predict_flush();
        t_tag_result res;
        int          first;
        first = expected_results.size();
        for (int i = 0; i < sctp_pkg::ENTRIES; i++) begin
            if (line_valid[i] && line_dirty[i]) begin
                res           = '0;
                res.entry     = sctp_pkg::IDX_W'(i);
                res.wb_valid  = 1'b1;
                res.wb_sector = line_sector[i];
                expected_results.push_back(res);
            end
            line_dirty[i]  = 1'b0;
            line_writes[i] = '0;
        end
        if (expected_results.size() == first) begin
            res      = '0;
            res.last = 1'b1;
            expected_results.push_back(res);
        end else begin
            expected_results[$].last = 1'b1;
        end
        flush_count++;
    endfunction

    // present one transaction and hold it until the block takes it
    task automatic send_item(input sctp_pkg::t_op op,
                             input logic [sctp_pkg::ADDR_W-1:0] addr);
        i_operation    <= op;
        i_byte_address <= addr;
        start          <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        accepted_count++;
        case (op)
            sctp_pkg::OP_READ:  predict_access(1'b0, addr);
            sctp_pkg::OP_WRITE: predict_access(1'b1, addr);
            sctp_pkg::OP_FLUSH: predict_flush();
            default:  ;
        endcase
    endtask

    // sender idle burst, optionally placed after the block has gone idle
    task automatic pause_sender(input int cycles, input bit after_busy);
        start          <= 1'b0;
        i_byte_address <= $urandom();
        if (after_busy)
            while (busy !== 1'b0) @(posedge i_clk);
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker
    t_tag_result oldest;
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_strobe === 1'b1) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result strobe with nothing expected, entry 0x%0h", $time,
                         o_entry_index);
                mismatch_count++;
            end else begin
                oldest = expected_results.pop_front();
                checked_count++;
                compare_field("hit",              32'(oldest.hit),
                              32'(o_hit));
                compare_field("entry_index",      32'(oldest.entry),
                              32'(o_entry_index));
                compare_field("writeback_valid",  32'(oldest.wb_valid),
                              32'(o_writeback_valid));
                compare_field("writeback_sector", 32'(oldest.wb_sector),
                              32'(o_writeback_sector));
                compare_field("fill_valid",       32'(oldest.fill_valid),
                              32'(o_fill_valid));
                compare_field("fill_sector",      32'(oldest.fill_sector),
                              32'(o_fill_sector));
                compare_field("last",             32'(oldest.last),
                              32'(o_last));
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start && busy === 1'b0) || o_result_strobe === 1'b1) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     expected_results.size());
            $display("sector_cache_tag_policy: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // hits, misses, free-entry allocation, clean eviction and the ignored code
    task automatic test_basic_access();
        send_item(sctp_pkg::OP_FLUSH, 32'h0000_0000);
        send_item(sctp_pkg::OP_READ,  32'h0000_0000);
        send_item(sctp_pkg::OP_READ,  32'h0000_01FF);
        send_item(sctp_pkg::OP_WRITE, 32'hFFFF_FFFF);
        send_item(sctp_pkg::OP_WRITE, 32'hFFFF_FE00);
        send_item(sctp_pkg::OP_NONE,  32'hA5A5_A5A5);
        for (int k = 1; k <= 6; k++)
            send_item((k % 2) ? sctp_pkg::OP_WRITE : sctp_pkg::OP_READ,
                      {sctp_pkg::SECTOR_W'(k * 32'h1357), sctp_pkg::SECTOR_SHIFT'(k)});
        send_item(sctp_pkg::OP_READ,  32'h1234_5600);
        send_item(sctp_pkg::OP_WRITE, 32'h2468_ACE0);
        send_item(sctp_pkg::OP_READ,  32'h0000_0000);
    endtask

    // fully dirty cache: dirty eviction, eight-result flush, then an empty flush
    task automatic test_flush_all_dirty();
        for (int k = 0; k < sctp_pkg::ENTRIES; k++)
            send_item(sctp_pkg::OP_WRITE,
                      {sctp_pkg::SECTOR_W'(32'h40_0000 + k * 32'h111),
                       sctp_pkg::SECTOR_SHIFT'(3 * k)});
        send_item(sctp_pkg::OP_FLUSH, 32'h5555_5555);
        for (int k = 0; k < sctp_pkg::ENTRIES; k++)
            send_item(sctp_pkg::OP_WRITE,
                      {sctp_pkg::SECTOR_W'(32'h20_0000 + k), sctp_pkg::SECTOR_SHIFT'(k)});
        send_item(sctp_pkg::OP_READ,  32'h7777_7777);
        send_item(sctp_pkg::OP_FLUSH, 32'hAAAA_AAAA);
        send_item(sctp_pkg::OP_FLUSH, 32'hFFFF_FFFF);
    endtask

    // a heavily written entry survives the next eviction, a lightly
    // written dirty one goes instead
    task automatic test_counter_victim();
        logic [sctp_pkg::SECTOR_W-1:0] hot;
        hot = sctp_pkg::SECTOR_W'($urandom());
        send_item(sctp_pkg::OP_FLUSH, 32'h0);
        repeat (HOT_WRITES)
            send_item(sctp_pkg::OP_WRITE, {hot, sctp_pkg::SECTOR_SHIFT'($urandom())});
        for (int k = 1; k < sctp_pkg::ENTRIES; k++)
            send_item(sctp_pkg::OP_WRITE,
                      {hot ^ sctp_pkg::SECTOR_W'(k), sctp_pkg::SECTOR_SHIFT'(k)});
        send_item(sctp_pkg::OP_READ, {~hot, sctp_pkg::SECTOR_SHIFT'(0)});
        send_item(sctp_pkg::OP_READ, {hot, sctp_pkg::SECTOR_SHIFT'(0)});
    endtask

    // random mix over small sector pools so that hits and evictions both occur
    task automatic test_random_mix();
        logic [sctp_pkg::SECTOR_W-1:0] pool [16];
        logic [sctp_pkg::ADDR_W-1:0]   addr;
        sctp_pkg::t_op                 op;
        int                            done_items;
        int                            span;
        int                            pick;
        pool[0] = '0;
        pool[1] = '1;
        for (int i = 2; i < 16; i++)
            pool[i] = sctp_pkg::SECTOR_W'($urandom());
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            span = (done_items < 80) ? 9 : (done_items < 160) ? 16 : 12;
            pick = $urandom_range(99);
            op   = (pick < 42) ? sctp_pkg::OP_READ : (pick < 84) ? sctp_pkg::OP_WRITE :
                   (pick < 94) ? sctp_pkg::OP_FLUSH : sctp_pkg::OP_NONE;
            if ($urandom_range(7) == 0)
                addr = $urandom();
            else
                addr = {pool[$urandom_range(span - 1)],
                        sctp_pkg::SECTOR_SHIFT'($urandom())};
            send_item(op, addr);
            if (op != sctp_pkg::OP_NONE)
                done_items++;
            // idle bursts, none in the closing stretch
            if (done_items < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(3) == 0)
                pause_sender($urandom_range(1, 5), 1'($urandom_range(1)));
        end
    endtask

    // test sequence
    initial begin
        for (int i = 0; i < sctp_pkg::ENTRIES; i++) begin
            line_valid[i]  = 1'b0;
            line_dirty[i]  = 1'b0;
            line_writes[i] = '0;
            line_sector[i] = '0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_access();
        test_flush_all_dirty();
        test_counter_victim();
        test_random_mix();

        // drain outstanding results
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d transactions taken, %0d results checked", accepted_count,
                 checked_count);
        $display("%0d hits, %0d dirty evictions, %0d flushes", hit_count, evict_wb_count,
                 flush_count);
        if (mismatch_count == 0) begin
            $display("sector_cache_tag_policy: match");
        end else begin
            $display("sector_cache_tag_policy: mismatch");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/sctp_pkg.sv
rtl/sector_cache_tag_policy.sv
test/tb_top.sv
